// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the token decoder.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, masked while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication check: when the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/lzo_pkg.sv -----
// Types and constants of the LZO1X token decoder.
// Depends on nothing; imported by lzo1x_token_decoder.
package lzo_pkg;

  // Width of the length counter; lengths clamp at 2^LENGTH_BITS - 1, never above 24 bits.
  localparam int LENGTH_BITS = 24;
  localparam int RUN_W       = 24;
  localparam logic [RUN_W:0] LEN_CAP =
    (LENGTH_BITS >= RUN_W) ? {1'b0, {RUN_W{1'b1}}}
                           : (RUN_W+1)'((64'd1 << LENGTH_BITS) - 64'd1);

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_COPY    = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

  // How an opcode below 16 reads.
  typedef enum logic [1:0] {
    CTX_A = 2'd0,  // literal run (after a match with no trailing literals)
    CTX_B = 2'd1,  // three-byte match at distance 0x0801 and up
    CTX_C = 2'd2,  // two-byte match (after 1 to 3 trailing literals)
    CTX_X = 2'd3   // unused, reads as CTX_A
  } ctx_t;

  // Parser phase, one-hot.
  typedef enum logic [8:0] {
    PH_START   = 9'b000000001,
    PH_OPCODE  = 9'b000000010,
    PH_LITEXT  = 9'b000000100,
    PH_LIT     = 9'b000001000,
    PH_SHORTB  = 9'b000010000,
    PH_M1B     = 9'b000100000,
    PH_MLENEXT = 9'b001000000,
    PH_D0      = 9'b010000000,
    PH_D1      = 9'b100000000
  } phase_t;

  // One result transaction.
  typedef struct packed {
    kind_t            kind;
    logic [7:0]       literal_byte;
    logic [15:0]      copy_distance;
    logic [RUN_W-1:0] copy_length;
    logic             length_saturated;
  } res_t;

  // Saturating length sum.
  typedef struct packed {
    logic [RUN_W-1:0] val;
    logic             clamp;
  } sat_t;

  function automatic sat_t sat_add(input logic [RUN_W-1:0] a, input logic [8:0] b);
    logic [RUN_W:0] sum;
    sat_t           r;
    sum = {1'b0, a} + {{(RUN_W-8){1'b0}}, b};
    if (sum > LEN_CAP) begin
      r.val   = LEN_CAP[RUN_W-1:0];
      r.clamp = 1'b1;
    end else begin
      r.val   = sum[RUN_W-1:0];
      r.clamp = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/lzo1x_token_decoder.sv -----
// LZO1X token decoder: parses a compressed byte stream into literal and copy transactions.
// Depends on lzo_pkg and assert_macros.svh.
//
// Usage: the input channel (in_valid, in_ready, in_byte) takes one compressed byte per
// transaction. The output channel (out_valid, out_ready and the result ports) carries a
// literal byte (kind 0), a back-reference copy command (kind 1, copy_distance and
// copy_length) or the end of stream (kind 2). Most bytes produce one result; opcode,
// length-extension and first-distance bytes produce none.
// A result is registered in the output register, or in the skid stage while that one
// stalls. Throughput is one byte per cycle while the skid stage is empty: the whole token
// step is a single pass of logic between the parser registers and the output register.
// After the end-of-stream result the parser is back in its stream-start state, so a new
// stream can follow immediately.
// Reset (synchronous, rst high) returns the parser to stream start and empties the
// output register and the skid stage.
// When the receiver stalls, one more result is held in a skid stage; in_ready drops only
// while that stage is occupied, so bytes that produce no result and one extra result
// still flow during a stall.
`include "assert_macros.svh"

module lzo1x_token_decoder
  import lzo_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       literal_byte,
  output logic [15:0]      copy_distance,
  output logic [RUN_W-1:0] copy_length,
  output logic             length_saturated
);

  // Parser state.
  phase_t           phase, phase_next;
  ctx_t             ctx, ctx_next;
  logic [RUN_W-1:0] run_count, run_count_next;
  logic [7:0]       saved_opcode, saved_opcode_next;
  logic [7:0]       low_dist, low_dist_next;
  logic             sat_flag, sat_flag_next;

  // Result of the byte presented this cycle.
  logic             res_valid;
  res_t             res;

  // Output register and skid stage.
  res_t             out_res;
  res_t             skid_res;
  logic             skid_valid;

  logic             in_fire;
  logic             out_fire;

  // Shared helper controls for the opcode and after-match steps.
  logic             do_op;
  logic             do_am;
  logic [1:0]       am_t;
  sat_t             sum;
  logic [RUN_W-1:0] run_dec;
  logic [13:0]      q;
  logic [8:0]       lenext_add;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    phase_next        = phase;
    ctx_next          = ctx;
    run_count_next    = run_count;
    saved_opcode_next = saved_opcode;
    low_dist_next     = low_dist;
    sat_flag_next     = sat_flag;
    res_valid         = 1'b0;
    res               = '0;
    do_op             = 1'b0;
    do_am             = 1'b0;
    am_t              = saved_opcode[1:0];
    q                 = {in_byte, low_dist[7:2]};
    run_dec           = (run_count != '0) ? run_count - RUN_W'(1) : run_count;
    // Length-extension addend: 255 for a zero byte, else base plus byte plus offset.
    if (in_byte == 8'd0) begin
      lenext_add = 9'd255;
    end else if (phase == PH_LITEXT) begin
      lenext_add = 9'd18 + {1'b0, in_byte};
    end else if (saved_opcode >= 8'd32) begin
      lenext_add = 9'd33 + {1'b0, in_byte};
    end else begin
      lenext_add = 9'd9 + {1'b0, in_byte};
    end
    sum = sat_add(run_count, lenext_add);

    case (phase)
      PH_OPCODE: begin
        do_op = 1'b1;
      end
      PH_LITEXT: begin
        run_count_next = sum.val;
        if (sum.clamp) begin
          sat_flag_next = 1'b1;
        end
        if (in_byte != 8'd0) begin
          ctx_next   = CTX_B;
          phase_next = PH_LIT;
        end
      end
      PH_LIT: begin
        run_count_next = run_dec;
        if (run_dec == '0) begin
          phase_next = PH_OPCODE;
        end
        res_valid            = 1'b1;
        res.kind             = KIND_LITERAL;
        res.literal_byte     = in_byte;
        res.length_saturated = sat_flag;
      end
      PH_SHORTB: begin
        res_valid = 1'b1;
        res.kind  = KIND_COPY;
        if (ctx == CTX_B) begin
          res.copy_distance = 16'h0801 + {10'd0, saved_opcode[7:2]} + {6'd0, in_byte, 2'b00};
          res.copy_length   = RUN_W'(3);
        end else begin
          res.copy_distance = 16'd1 + {10'd0, saved_opcode[7:2]} + {6'd0, in_byte, 2'b00};
          res.copy_length   = RUN_W'(2);
        end
        do_am = 1'b1;
      end
      PH_M1B: begin
        res_valid         = 1'b1;
        res.kind          = KIND_COPY;
        res.copy_distance = 16'd1 + {13'd0, saved_opcode[4:2]} + {5'd0, in_byte, 3'b000};
        res.copy_length   = {{(RUN_W-3){1'b0}}, saved_opcode[7:5]} + RUN_W'(1);
        do_am             = 1'b1;
      end
      PH_MLENEXT: begin
        run_count_next = sum.val;
        if (sum.clamp) begin
          sat_flag_next = 1'b1;
        end
        if (in_byte != 8'd0) begin
          phase_next = PH_D0;
        end
      end
      PH_D0: begin
        low_dist_next = in_byte;
        phase_next    = PH_D1;
      end
      PH_D1: begin
        res_valid = 1'b1;
        if (saved_opcode >= 8'd32) begin
          res.kind             = KIND_COPY;
          res.copy_distance    = 16'd1 + {2'b00, q};
          res.copy_length      = run_count;
          res.length_saturated = sat_flag;
          am_t                 = low_dist[1:0];
          do_am                = 1'b1;
        end else if (!saved_opcode[3] && q == '0) begin
          // End-of-stream marker: everything returns to its reset value.
          res.kind          = KIND_END;
          phase_next        = PH_START;
          ctx_next          = CTX_A;
          run_count_next    = '0;
          saved_opcode_next = '0;
          low_dist_next     = '0;
          sat_flag_next     = 1'b0;
        end else begin
          res.kind             = KIND_COPY;
          res.copy_distance    = {1'b0, saved_opcode[3], q} + 16'h4000;
          res.copy_length      = run_count;
          res.length_saturated = sat_flag;
          am_t                 = low_dist[1:0];
          do_am                = 1'b1;
        end
      end
      default: begin
        // Stream start, and any phase code without meaning.
        ctx_next = CTX_A;
        if (in_byte > 8'd17) begin
          sat_flag_next  = 1'b0;
          run_count_next = RUN_W'(in_byte - 8'd17);
          ctx_next       = (in_byte < 8'd21) ? CTX_C : CTX_B;
          phase_next     = PH_LIT;
        end else begin
          do_op = 1'b1;
        end
      end
    endcase

    if (do_op) begin
      sat_flag_next     = 1'b0;
      saved_opcode_next = in_byte;
      if (in_byte >= 8'd64) begin
        phase_next = PH_M1B;
      end else if (in_byte >= 8'd16) begin
        if ((in_byte >= 8'd32 && in_byte[4:0] == 5'd0) ||
            (in_byte < 8'd32 && in_byte[2:0] == 3'd0)) begin
          run_count_next = '0;
          phase_next     = PH_MLENEXT;
        end else begin
          run_count_next = (in_byte >= 8'd32)
                           ? {{(RUN_W-5){1'b0}}, in_byte[4:0]} + RUN_W'(2)
                           : {{(RUN_W-3){1'b0}}, in_byte[2:0]} + RUN_W'(2);
          phase_next     = PH_D0;
        end
      end else if (ctx_next == CTX_B || ctx_next == CTX_C) begin
        phase_next = PH_SHORTB;
      end else if (in_byte == 8'd0) begin
        run_count_next = '0;
        phase_next     = PH_LITEXT;
      end else begin
        run_count_next = {{(RUN_W-8){1'b0}}, in_byte} + RUN_W'(3);
        ctx_next       = CTX_B;
        phase_next     = PH_LIT;
      end
    end

    // After a match: trailing literals open a short run, none means an opcode follows.
    if (do_am) begin
      if (am_t == 2'd0) begin
        ctx_next   = CTX_A;
        phase_next = PH_OPCODE;
      end else begin
        sat_flag_next  = 1'b0;
        run_count_next = {{(RUN_W-2){1'b0}}, am_t};
        ctx_next       = CTX_C;
        phase_next     = PH_LIT;
      end
    end
  end

  // Parser registers advance only on an accepted input transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      ctx          <= CTX_A;
      run_count    <= '0;
      saved_opcode <= '0;
      low_dist     <= '0;
      sat_flag     <= 1'b0;
    end else if (in_fire) begin
      phase        <= phase_next;
      ctx          <= ctx_next;
      run_count    <= run_count_next;
      saved_opcode <= saved_opcode_next;
      low_dist     <= low_dist_next;
      sat_flag     <= sat_flag_next;
    end
  end

  // Output register with a one-entry skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire && res_valid;
      end
    end else if (in_fire && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else begin
        out_res <= res;
      end
    end else if (in_fire && res_valid) begin
      skid_res <= res;
    end
  end

  assign kind             = out_res.kind;
  assign literal_byte     = out_res.literal_byte;
  assign copy_distance    = out_res.copy_distance;
  assign copy_length      = out_res.copy_length;
  assign length_saturated = out_res.length_saturated;

  // The skid stage is only filled behind a stalled output register.
  `ASSERT_CLK(a_skid_behind_out, skid_valid |-> out_valid,
              "skid stage holds a result while the output register is empty")
  // A literal run always carries the match context that follows it.
  `ASSERT_CLK(a_lit_ctx, (phase == PH_LIT) |-> (ctx == CTX_B || ctx == CTX_C),
              "literal run with a literal-run context")
  // Lengths never exceed the clamp value.
  `ASSERT_CLK(a_run_cap, ({1'b0, run_count} <= LEN_CAP),
              "length counter above its clamp value")
  // End of stream returns the parser to stream start.
  `ASSERT_NEXT(a_end_restart, in_fire && res_valid && res.kind == KIND_END,
               phase == PH_START && run_count == '0 && !sat_flag,
               "parser not back at stream start after end of stream")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the LZO1X token decoder: a byte driver, a result monitor and
// a behavioral token parser that predicts every literal, copy and end-of-stream result.
// Depends on lzo_pkg and lzo1x_token_decoder.
module testbench;
  import lzo_pkg::*;

  // Generous cycle budget for under 900 bytes with idle and stall phases.
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned RANDOM_PER_PHASE = 155;
  localparam int unsigned EXT_ZEROS = 20;
  localparam int NUM_PHASES = 5;
  localparam int unsigned SEND_IDLE [NUM_PHASES] = '{0, 50, 0, 25, 0};
  localparam int unsigned RECV_STALL [NUM_PHASES] = '{0, 0, 50, 25, 0};

  // Hand-made opening streams. They walk most token forms and each context and end twice:
  // once with length extension bytes ahead of the end marker, once with the plain marker.
  localparam int NUM_OPENING = 41;
  localparam logic [7:0] OPENING [NUM_OPENING] = '{
    8'h12, 8'hFF,                             // one leading literal, two-byte context next
    8'h03, 8'hFF, 8'h00, 8'h80, 8'h7F,        // two-byte match, three trailing literals
    8'hFF, 8'h00, 8'h01, 8'h02, 8'hFE,        // short-distance match, three trailing
    8'h20, 8'h00, 8'h01, 8'hFC, 8'hFF,        // long match with length extension
    8'h01, 8'hAA, 8'h55, 8'h0F, 8'hF0,        // literal run of four
    8'h00, 8'h00,                             // three-byte match after a literal run
    8'h10, 8'h00, 8'hFF, 8'h01, 8'h00,        // end marker behind length bytes
    8'h11, 8'h04, 8'h00,                      // opcode as the first byte of a stream
    8'h18, 8'h01, 8'h00, 8'h00,               // far match with the high distance bit
    8'h40, 8'h12,                             // short-distance match, no trailing
    8'h11, 8'h00, 8'h00                       // plain end marker
  };

  // Parser state as the predictor tracks it.
  typedef struct {
    phase_t           phase;
    ctx_t             ctx;
    logic [RUN_W-1:0] run;
    logic [7:0]       op;
    logic [7:0]       dist_lo;
    logic             sat;
  } parser_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_byte = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       kind;
  logic [7:0]       literal_byte;
  logic [15:0]      copy_distance;
  logic [RUN_W-1:0] copy_length;
  logic             length_saturated;

  // Bytes waiting to be driven, and decoded results waiting to be seen on the output.
  logic [7:0]  stream_bytes [$];
  res_t        expected_tokens [$];

  // Two copies of the parser: one follows the bytes the block accepts, the other follows
  // the bytes the stimulus generator has queued, so that it can pick well-formed tokens.
  parser_t     tracked;
  parser_t     gen_parse;
  bit          ending = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  lzo1x_token_decoder uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .literal_byte     (literal_byte),
    .copy_distance    (copy_distance),
    .copy_length      (copy_length),
    .length_saturated (length_saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  //--------------------------------------------------------------------------------------
  // Token parser used for prediction.
  //--------------------------------------------------------------------------------------

  function automatic parser_t parser_reset();
    parser_t s;
    s.phase   = PH_START;
    s.ctx     = CTX_A;
    s.run     = '0;
    s.op      = 8'h00;
    s.dist_lo = 8'h00;
    s.sat     = 1'b0;
    return s;
  endfunction

  // Lengths and literal counts grow by saturating sums; hitting the cap marks the token.
  function automatic void grow(inout parser_t s, input int unsigned inc);
    logic [RUN_W:0] sum;
    sum = {1'b0, s.run} + (RUN_W + 1)'(inc);
    if (sum > LEN_CAP) begin
      s.run = LEN_CAP[RUN_W-1:0];
      s.sat = 1'b1;
    end else begin
      s.run = sum[RUN_W-1:0];
    end
  endfunction

  // The low two bits of the opcode or of the first distance byte give the count of trailing literals.
  function automatic void close_match(inout parser_t s, input logic [7:0] tail);
    if (tail[1:0] == 2'd0) begin
      s.ctx   = CTX_A;
      s.phase = PH_OPCODE;
    end else begin
      s.sat   = 1'b0;
      s.run   = RUN_W'(tail[1:0]);
      s.ctx   = CTX_C;
      s.phase = PH_LIT;
    end
  endfunction

  function automatic void take_opcode(inout parser_t s, input logic [7:0] b);
    logic [4:0] len_bits;
    s.sat = 1'b0;
    s.op  = b;
    if (b >= 8'd64) begin
      s.phase = PH_M1B;
    end else if (b >= 8'd16) begin
      len_bits = (b >= 8'd32) ? b[4:0] : {2'b00, b[2:0]};
      if (len_bits == 5'd0) begin
        s.run   = '0;
        s.phase = PH_MLENEXT;
      end else begin
        s.run   = RUN_W'(len_bits) + RUN_W'(2);
        s.phase = PH_D0;
      end
    end else if (s.ctx == CTX_B || s.ctx == CTX_C) begin
      s.phase = PH_SHORTB;
    end else if (b == 8'd0) begin
      s.run   = '0;
      s.phase = PH_LITEXT;
    end else begin
      s.run   = RUN_W'(b) + RUN_W'(3);
      s.ctx   = CTX_B;
      s.phase = PH_LIT;
    end
  endfunction

  // Advances the parser by one compressed byte; returns 1 when the byte yields a result.
  function automatic bit decode_byte(inout parser_t s, input logic [7:0] b, output res_t r);
    int unsigned      copy_dist;
    int unsigned      q;
    logic [RUN_W-1:0] len;
    logic             sat;
    logic [7:0]       op;
    r  = '0;
    op = s.op;
    case (s.phase)
      PH_OPCODE: begin
        take_opcode(s, b);
        return 1'b0;
      end
      PH_LITEXT: begin
        if (b == 8'd0) begin
          grow(s, 255);
        end else begin
          grow(s, 18 + 32'(b));
          s.ctx   = CTX_B;
          s.phase = PH_LIT;
        end
        return 1'b0;
      end
      PH_LIT: begin
        sat = s.sat;
        if (s.run != '0) s.run = s.run - 1'b1;
        if (s.run == '0) s.phase = PH_OPCODE;
        r.kind             = KIND_LITERAL;
        r.literal_byte     = b;
        r.length_saturated = sat;
        return 1'b1;
      end
      PH_SHORTB: begin
        // A long literal run leaves the far three-byte form, trailing literals the near one.
        if (s.ctx == CTX_B) begin
          copy_dist = 32'h0801 + 32'(op[7:2]) + (32'(b) << 2);
          len       = RUN_W'(3);
        end else begin
          copy_dist = 1 + 32'(op[7:2]) + (32'(b) << 2);
          len       = RUN_W'(2);
        end
        close_match(s, op);
        r.kind          = KIND_COPY;
        r.copy_distance = copy_dist[15:0];
        r.copy_length   = len;
        return 1'b1;
      end
      PH_M1B: begin
        copy_dist = 1 + 32'(op[4:2]) + (32'(b) << 3);
        len       = RUN_W'(op[7:5]) + RUN_W'(1);
        close_match(s, op);
        r.kind          = KIND_COPY;
        r.copy_distance = copy_dist[15:0];
        r.copy_length   = len;
        return 1'b1;
      end
      PH_MLENEXT: begin
        if (b == 8'd0) begin
          grow(s, 255);
        end else begin
          grow(s, ((op >= 8'd32) ? 31 : 7) + 32'(b) + 2);
          s.phase = PH_D0;
        end
        return 1'b0;
      end
      PH_D0: begin
        s.dist_lo = b;
        s.phase   = PH_D1;
        return 1'b0;
      end
      PH_D1: begin
        q   = {16'd0, b, s.dist_lo} >> 2;
        len = s.run;
        sat = s.sat;
        if (op >= 8'd32) begin
          copy_dist = 1 + q;
        end else begin
          copy_dist = (op[3] ? 32'h4000 : 32'd0) + q;
          // A zero distance in the far form is the end marker; the parser starts over.
          if (copy_dist == 0) begin
            s      = parser_reset();
            r.kind = KIND_END;
            return 1'b1;
          end
          copy_dist = copy_dist + 32'h4000;
        end
        close_match(s, s.dist_lo);
        r.kind             = KIND_COPY;
        r.copy_distance    = copy_dist[15:0];
        r.copy_length      = len;
        r.length_saturated = sat;
        return 1'b1;
      end
      default: begin
        // First byte of a stream: above 17 it opens a literal run directly.
        s.ctx = CTX_A;
        if (b > 8'd17) begin
          s.sat   = 1'b0;
          s.run   = RUN_W'(b - 8'd17);
          s.ctx   = (b - 8'd17 < 8'd4) ? CTX_C : CTX_B;
          s.phase = PH_LIT;
        end else begin
          take_opcode(s, b);
        end
        return 1'b0;
      end
    endcase
  endfunction

  //--------------------------------------------------------------------------------------
  // Stimulus generation.
  //--------------------------------------------------------------------------------------

  // Opcode mix over all token forms; now and then an end marker is started on purpose.
  function automatic logic [7:0] choose_opcode();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      ending = 1'b1;
      return 8'($urandom_range(16, 23));
    end
    if (pick < 30) return 8'($urandom_range(0, 15));
    if (pick < 50) return 8'($urandom_range(16, 31));
    if (pick < 75) return 8'($urandom_range(32, 63));
    return 8'($urandom_range(64, 255));
  endfunction

  // Picks the next byte to suit what the generator's parser copy expects. A share of the
  // bytes is plain noise, which breaks tokens and exercises odd paths.
  function automatic logic [7:0] choose_byte();
    if ($urandom_range(0, 99) < 8) return 8'($urandom);
    case (gen_parse.phase)
      PH_START: begin
        if ($urandom_range(0, 99) < 30) return choose_opcode();
        if ($urandom_range(0, 99) < 80) return 8'($urandom_range(18, 40));
        return 8'($urandom_range(18, 255));
      end
      PH_OPCODE: return choose_opcode();
      PH_LITEXT: begin
        if (gen_parse.run < 600 && $urandom_range(0, 99) < 20) return 8'h00;
        if ($urandom_range(0, 99) < 70) return 8'($urandom_range(1, 15));
        return 8'($urandom_range(1, 255));
      end
      PH_MLENEXT: begin
        if (gen_parse.run < 2000 && $urandom_range(0, 99) < 35) return 8'h00;
        return 8'($urandom_range(1, 255));
      end
      PH_D0: begin
        if (ending) return 8'($urandom_range(0, 3));
        return 8'($urandom);
      end
      PH_D1: begin
        if (ending) begin
          ending = 1'b0;
          return 8'h00;
        end
        return 8'($urandom);
      end
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send(input logic [7:0] b);
    res_t scratch;
    stream_bytes.push_back(b);
    void'(decode_byte(gen_parse, b, scratch));
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) send(choose_byte());
  endtask

  // Waits until every queued byte is taken and every predicted result has come out.
  task automatic drain();
    while (stream_bytes.size() != 0 || in_valid || expected_tokens.size() != 0)
      @(negedge clk);
  endtask

  //--------------------------------------------------------------------------------------
  // Driver: presents queued bytes, keeps a byte steady until the block takes it, and feeds
  // each accepted byte to the tracking parser to predict the result.
  //--------------------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t predicted;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (decode_byte(tracked, in_byte, predicted)) expected_tokens.push_back(predicted);
      end
      // A new byte may go out only when no byte is held waiting for acceptance.
      if (!in_valid || in_ready) begin
        if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_byte  <= stream_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  //--------------------------------------------------------------------------------------
  // Monitor: every result transaction is checked against the oldest prediction. The ready
  // line stalls at random according to the current phase.
  //--------------------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing expected: kind %0d lit %h dist %h len %h sat %b",
                     $realtime, kind, literal_byte, copy_distance, copy_length,
                     length_saturated);
        end else begin
          want = expected_tokens.pop_front();
          if (kind !== want.kind || literal_byte !== want.literal_byte ||
              copy_distance !== want.copy_distance || copy_length !== want.copy_length ||
              length_saturated !== want.length_saturated) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: expected kind %0d lit %h dist %h len %h sat %b",
                       $realtime, want.kind, want.literal_byte, want.copy_distance,
                       want.copy_length, want.length_saturated);
              $display("%0t:           got kind %0d lit %h dist %h len %h sat %b",
                       $realtime, kind, literal_byte, copy_distance, copy_length,
                       length_saturated);
            end
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  //--------------------------------------------------------------------------------------
  // Sequence: reset, then phases with their own idle and stall patterns. Between phases the sender
  // holds off until every predicted result has been seen.
  //--------------------------------------------------------------------------------------
  initial begin
    tracked   = parser_reset();
    gen_parse = parser_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      @(negedge clk);
      send_idle_pct = SEND_IDLE[p];
      stall_pct     = RECV_STALL[p];
      if (p == 0) begin
        foreach (OPENING[i]) send(OPENING[i]);
        // A zero-length long match extended by a run of zero bytes, closed with a copy,
        // then the end marker.
        send(8'h10);
        for (int unsigned z = 0; z < EXT_ZEROS; z++) send(8'h00);
        send(8'h05);
        send(8'h08);
        send(8'h00);
        send(8'h11);
        send(8'h00);
        send(8'h00);
      end
      send_random(RANDOM_PER_PHASE);
      drain();
    end

    // Keep running so that a stray extra result would still be caught.
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/lzo_pkg.sv
rtl/core/lzo1x_token_decoder.sv
tb/testbench.sv
